// File: hw/rtl/msd_pkg.sv
package msd_pkg;

   localparam int SAMPLE_W        = 32;
   localparam int CNT_W           = 17;
   localparam int SUM_W           = 48;
   localparam int SQ_W            = 2 * SAMPLE_W;
   localparam int SUM_SQ_W        = 80;
   localparam int PROD_W          = 97;
   localparam int ROOT_W          = 50;
   localparam int RAD_W           = 2 * ROOT_W;
   localparam int REM_W           = ROOT_W + 1;
   localparam int DIV_W           = ROOT_W;
   localparam int ITER_W          = $clog2(ROOT_W);
   localparam int MAX_SAMPLES_DEF = 65536;
   localparam int REQ_TDATA_W     = 32;
   localparam int REQ_TUSER_W     = 1;
   localparam int RSP_TDATA_W     = 88;
   localparam int RSP_TUSER_W     = 2;

   typedef enum logic [7:0] {
      ST_ACCUM = 8'b0000_0001,
      ST_DRAIN = 8'b0000_0010,
      ST_MUL_N = 8'b0000_0100,
      ST_MUL_S = 8'b0000_1000,
      ST_SUB   = 8'b0001_0000,
      ST_SQRT  = 8'b0010_0000,
      ST_DIV_M = 8'b0100_0000,
      ST_DIV_S = 8'b1000_0000
   } state_type;

endpackage

// File: hw/rtl/msd_isqrt.sv
module msd_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [msd_pkg::RAD_W-1:0]  radicand,
   output logic                       done,
   output logic [msd_pkg::ROOT_W-1:0] root
);
   import msd_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W+1:0]  rem_sh;
   logic [REM_W+1:0]  trial;
   logic [REM_W+1:0]  rem_diff;
   logic              fits;

   // bring down two radicand bits, try (root << 2) | 1
   always_comb begin
      rem_sh   = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial    = {1'b0, root_ff, 2'b01};
      fits     = (rem_sh >= trial);
      rem_diff = rem_sh - trial;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = ITER_W'(ROOT_W - 1);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         rem_in  = fits ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: hw/rtl/msd_div.sv
module msd_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [msd_pkg::DIV_W-1:0] dividend,
   input  logic [msd_pkg::CNT_W-1:0] divisor,
   output logic                      done,
   output logic [msd_pkg::DIV_W-1:0] quotient
);
   import msd_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W:0]    rem_sh;
   logic [CNT_W:0]    rem_diff;
   logic              fits;

   // restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      rem_sh   = {rem_ff, quo_ff[DIV_W-1]};
      fits     = (rem_sh >= {1'b0, dsr_ff});
      rem_diff = rem_sh - {1'b0, dsr_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = ITER_W'(DIV_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hw/rtl/sample_mean_and_std_dev_unit.sv
// Channel   Dir  Payload (lowest bits first)
// req_*     in   tdata: sample_ticks[31:0]; tuser: has_sample; tlast: last
// rsp_*     out  tdata: mean_ticks[31:0], std_dev_ticks[63:32], sample_count[80:64];
//                tuser: empty_res[0], overflowed[1]
//
// Samples: one per cycle while req_tready is high; the registered 32x32 square joins the
// sum of squares in the cycle after the sample is taken. A tlast request blocks req_tready
// through drain, the N*S2 and S1*S1 multiplies, subtract, square root, two divides and a
// hand-off, one bit or digit per cycle. An empty set blocks for drain and hand-off only.
// New samples flow while a result waits in rsp_*; the next tlast holds in hand-off until it is taken.
// Reset is synchronous and clears the accumulators and the handshake state.
module sample_mean_and_std_dev_unit #(
   parameter int MAX_SAMPLES = msd_pkg::MAX_SAMPLES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [msd_pkg::REQ_TDATA_W-1:0] req_tdata,  // sample_ticks[31:0]
   input  logic [msd_pkg::REQ_TUSER_W-1:0] req_tuser,  // has_sample[0]
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // mean_ticks[31:0], std_dev_ticks[63:32], sample_count[80:64], zero fill above
   output logic [msd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [msd_pkg::RSP_TUSER_W-1:0] rsp_tuser   // empty_res[0], overflowed[1]
);
   import msd_pkg::*;

   state_type           state_ff, state_in;

   // accumulators
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUM_SQ_W-1:0] sum_sq_ff, sum_sq_in;
   logic                ovf_ff, ovf_in;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic                sq_vld_ff, sq_vld_in;

   // shift-add multiplier
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [PROD_W-1:0]   ns2_ff, ns2_in;
   logic [SUM_W-1:0]    mult_ff, mult_in;
   logic [ITER_W-1:0]   step_ff, step_in;
   logic [PROD_W-1:0]   addend;
   logic [PROD_W-1:0]   prod_step;
   logic [PROD_W-1:0]   var_term;

   // results
   logic [SAMPLE_W-1:0] mean_ff, mean_in;
   logic [SAMPLE_W-1:0] std_ff, std_in;
   logic                fin_ff, fin_in;

   // output register
   logic                rsp_vld_ff, rsp_vld_in;
   logic [SAMPLE_W-1:0] rsp_mean_ff, rsp_mean_in;
   logic [SAMPLE_W-1:0] rsp_std_ff, rsp_std_in;
   logic [CNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic                req_fire;
   logic                keep_sample;
   logic                sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]   root;
   logic                div_start, div_done;
   logic [DIV_W-1:0]    div_dividend;
   logic [DIV_W-1:0]    quotient;
   logic                out_free;

   assign req_tready  = (state_ff == ST_ACCUM) && !fin_ff;
   assign req_fire    = req_tvalid && req_tready;
   assign keep_sample = req_fire && req_tuser[0] && (count_ff < CNT_W'(MAX_SAMPLES));
   assign out_free    = !rsp_vld_ff || rsp_tready;

   // one partial product per cycle, multiplier bits taken from the top
   always_comb begin
      addend    = (state_ff == ST_MUL_N) ? PROD_W'(sum_sq_ff) : PROD_W'(sum_ff);
      prod_step = {prod_ff[PROD_W-2:0], 1'b0} + (mult_ff[SUM_W-1] ? addend : '0);
      var_term  = (ns2_ff >= prod_ff) ? (ns2_ff - prod_ff) : '0;
   end

   assign sqrt_start   = (state_ff == ST_SUB);
   assign div_start    = ((state_ff == ST_SQRT) && sqrt_done) ||
                         ((state_ff == ST_DIV_M) && div_done);
   assign div_dividend = (state_ff == ST_SQRT) ? DIV_W'(sum_ff) : root;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      sum_sq_in    = sum_sq_ff;
      ovf_in       = ovf_ff;
      sq_in        = sq_ff;
      sq_vld_in    = 1'b0;
      prod_in      = prod_ff;
      ns2_in       = ns2_ff;
      mult_in      = mult_ff;
      step_in      = step_ff;
      mean_in      = mean_ff;
      std_in       = std_ff;
      fin_in       = fin_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_mean_in  = rsp_mean_ff;
      rsp_std_in   = rsp_std_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      // fold the square of the previous sample into the sum of squares
      if (sq_vld_ff) begin
         sum_sq_in = sum_sq_ff + SUM_SQ_W'(sq_ff);
      end

      case (state_ff)
         ST_ACCUM: begin
            if (fin_ff) begin
               // hold the finished result until the output register frees up
               if (out_free) begin
                  rsp_vld_in   = 1'b1;
                  rsp_mean_in  = mean_ff;
                  rsp_std_in   = std_ff;
                  rsp_cnt_in   = count_ff;
                  rsp_empty_in = (count_ff == '0);
                  rsp_ovf_in   = ovf_ff;
                  fin_in       = 1'b0;
                  count_in     = '0;
                  sum_in       = '0;
                  sum_sq_in    = '0;
                  ovf_in       = 1'b0;
               end
            end else if (req_fire) begin
               if (req_tuser[0] && !keep_sample) begin
                  ovf_in = 1'b1;
               end
               if (keep_sample) begin
                  count_in  = count_ff + 1'b1;
                  sum_in    = sum_ff + SUM_W'(req_tdata);
                  sq_in     = SQ_W'(req_tdata) * SQ_W'(req_tdata);
                  sq_vld_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (count_ff == '0) begin
               mean_in  = '0;
               std_in   = '0;
               fin_in   = 1'b1;
               state_in = ST_ACCUM;
            end else begin
               prod_in  = '0;
               mult_in  = {count_ff, {(SUM_W-CNT_W){1'b0}}};
               step_in  = ITER_W'(CNT_W - 1);
               state_in = ST_MUL_N;
            end
         end
         ST_MUL_N: begin
            prod_in = prod_step;
            mult_in = {mult_ff[SUM_W-2:0], 1'b0};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               ns2_in   = prod_step;
               prod_in  = '0;
               mult_in  = sum_ff;
               step_in  = ITER_W'(SUM_W - 1);
               state_in = ST_MUL_S;
            end
         end
         ST_MUL_S: begin
            prod_in = prod_step;
            mult_in = {mult_ff[SUM_W-2:0], 1'b0};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            // square root picks up N*S2 - S1*S1 this cycle
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               state_in = ST_DIV_M;
            end
         end
         ST_DIV_M: begin
            if (div_done) begin
               mean_in  = quotient[SAMPLE_W-1:0];
               state_in = ST_DIV_S;
            end
         end
         ST_DIV_S: begin
            if (div_done) begin
               std_in   = quotient[SAMPLE_W-1:0];
               fin_in   = 1'b1;
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_ACCUM;
         count_ff   <= '0;
         sum_ff     <= '0;
         sum_sq_ff  <= '0;
         ovf_ff     <= 1'b0;
         sq_vld_ff  <= 1'b0;
         fin_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         sum_ff     <= sum_in;
         sum_sq_ff  <= sum_sq_in;
         ovf_ff     <= ovf_in;
         sq_vld_ff  <= sq_vld_in;
         fin_ff     <= fin_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      sq_ff        <= sq_in;
      prod_ff      <= prod_in;
      ns2_ff       <= ns2_in;
      mult_ff      <= mult_in;
      step_ff      <= step_in;
      mean_ff      <= mean_in;
      std_ff       <= std_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_std_ff   <= rsp_std_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   msd_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (RAD_W'(var_term)),
      .done     (sqrt_done),
      .root     (root)
   );

   msd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - 2*SAMPLE_W - CNT_W){1'b0}},
                        rsp_cnt_ff, rsp_std_ff, rsp_mean_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_empty_ff};

   // the square must be folded in before the multiply steps read the sum of squares
   a_sq_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ACCUM && state_ff != ST_DRAIN) |-> !sq_vld_ff)
      else $error("square still pending after drain");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count past capacity");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> (state_ff == ST_DRAIN))
      else $error("closing request did not start drain");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_empty_ff) |->
         (rsp_mean_ff == '0 && rsp_std_ff == '0 && rsp_cnt_ff == '0))
      else $error("empty result carries nonzero fields");

endmodule
